FILE: rtl/nec_ir_pkg.sv
// Shared types and constants for the NEC infrared pulse-width decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package nec_ir_pkg;

  // Event kinds carried on the input word's tuser
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_RISE = 2'd1,
    OP_FALL = 2'd2,
    OP_SCAN = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [7:0] REG_DEV_ADDR      = 8'd0;
  localparam logic [7:0] REG_RELEASE_TICKS = 8'd1;

  localparam logic [7:0] DEV_ADDR_RST      = 8'd0;
  localparam logic [3:0] RELEASE_TICKS_RST = 4'd14;

  // High-time windows in microseconds (exclusive bounds)
  localparam logic [15:0] BIT0_LO = 16'd300;
  localparam logic [15:0] BIT0_HI = 16'd800;
  localparam logic [15:0] BIT1_LO = 16'd1400;
  localparam logic [15:0] BIT1_HI = 16'd1800;
  localparam logic [15:0] REP_LO  = 16'd2200;
  localparam logic [15:0] REP_HI  = 16'd2600;
  localparam logic [15:0] LEAD_LO = 16'd4200;
  localparam logic [15:0] LEAD_HI = 16'd4700;

  // Window hits for one high time
  typedef struct packed {
    logic bit0;
    logic bit1;
    logic rpt;
    logic lead;
  } win_t;

  // One scan result
  typedef struct packed {
    logic       frame_active;
    logic [7:0] repeat_count;
    logic       key_valid;
    logic [7:0] key_code;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/nec_ir_pulse_width_decoder.sv
// Top level of the NEC infrared pulse-width decoder: input word register,
// configuration registers, result register. Uses nec_ir_pkg, nec_ir_classify
// and nec_ir_core.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-------------------------------------
//   in      | in  | in_tvalid/in_tready   | tuser op, tdata high_width
//   out     | out | out_tvalid/out_tready | tdata key_code..frame_active
//   cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One word per cycle while no scan word waits: a word is held in the input register,
// then updates the decoder state; a scan word loads the result register,
// from which its result is offered.
// A scan word meeting a stalled, full result register waits in the input
// register and holds the input; tick and edge words never wait.
// Reset (synchronous, rst_n low) clears the valid flags and decoder state and restores config defaults.
`default_nettype none

module nec_ir_pulse_width_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input words
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] high_width
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  // result words
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // [7:0] key_code, [8] key_valid,
                                       // [16:9] repeat_count, [17] frame_active,
                                       // [23:18] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import nec_ir_pkg::*;

  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [15:0] s1_width_r;
  logic        s1_adv;

  logic [7:0]  dev_addr_r;
  logic [3:0]  release_ticks_r;

  logic        out_valid_r;
  res_t        out_res_r;

  win_t        win;
  res_t        res;

  // Advance the input word unless a scan meets a full result register
  assign s1_adv    = s1_valid_r &&
                     ((s1_op_r != OP_SCAN) || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign cfg_ready = 1'b1;

  // Input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= op_t'(in_tuser);
      s1_width_r <= in_tdata;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r      <= DEV_ADDR_RST;
      release_ticks_r <= RELEASE_TICKS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEV_ADDR) begin
        dev_addr_r <= cfg_data;
      end
      if (cfg_index == REG_RELEASE_TICKS) begin
        release_ticks_r <= cfg_data[3:0];
      end
    end
  end

  nec_ir_classify u_classify (
    .high_width (s1_width_r),
    .win        (win)
  );

  nec_ir_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (s1_adv),
    .op            (s1_op_r),
    .win           (win),
    .dev_addr      (dev_addr_r),
    .release_ticks (release_ticks_r),
    .res           (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && (s1_op_r == OP_SCAN)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_op_r == OP_SCAN)) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r};

endmodule

`default_nettype wire

FILE: rtl/nec_ir_classify.sv
// High-time window classifier: compares the measured width against the
// bit-0, bit-1, repeat and lead windows. Depends on nec_ir_pkg.
`default_nettype none

module nec_ir_classify (
  input  wire logic [15:0]      high_width,
  output nec_ir_pkg::win_t      win
);
  import nec_ir_pkg::*;

  // Flag each window the width falls strictly inside
  always_comb begin
    win.bit0 = (high_width > BIT0_LO) && (high_width < BIT0_HI);
    win.bit1 = (high_width > BIT1_LO) && (high_width < BIT1_HI);
    win.rpt  = (high_width > REP_LO)  && (high_width < REP_HI);
    win.lead = (high_width > LEAD_LO) && (high_width < LEAD_HI);
  end

endmodule

`default_nettype wire

FILE: rtl/nec_ir_core.sv
// Decoder state and per-event update: lead/ready/high flags, tick counter,
// code shift register, repeat counter and scan check. Depends on nec_ir_pkg.
`default_nettype none

module nec_ir_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  nec_ir_pkg::op_t       op,
  input  nec_ir_pkg::win_t      win,
  input  wire logic [7:0]       dev_addr,
  input  wire logic [3:0]       release_ticks,
  output nec_ir_pkg::res_t      res
);
  import nec_ir_pkg::*;

  logic        lead_seen_r, lead_seen_nxt;
  logic        key_ready_r, key_ready_nxt;
  logic        high_seen_r, high_seen_nxt;
  logic [3:0]  tick_count_r, tick_count_nxt;
  logic [31:0] code_shift_r, code_shift_nxt;
  logic [7:0]  repeats_r, repeats_nxt;

  logic [7:0]  addr, naddr, cmd, ncmd;
  logic [7:0]  key;

  // Check address against complement and id, command against complement
  always_comb begin
    addr  = code_shift_r[31:24];
    naddr = code_shift_r[23:16];
    cmd   = code_shift_r[15:8];
    ncmd  = code_shift_r[7:0];
    key   = 8'd0;
    if (key_ready_r && (addr == ~naddr) && (addr == dev_addr) && (cmd == ~ncmd)) begin
      key = cmd;
    end
  end

  // Scan result reflects state as it stands before the event
  always_comb begin
    res.key_code     = key;
    res.key_valid    = (key != 8'd0);
    res.repeat_count = repeats_r;
    res.frame_active = lead_seen_r;
  end

  // Next state for one event
  always_comb begin
    lead_seen_nxt  = lead_seen_r;
    key_ready_nxt  = key_ready_r;
    high_seen_nxt  = high_seen_r;
    tick_count_nxt = tick_count_r;
    code_shift_nxt = code_shift_r;
    repeats_nxt    = repeats_r;
    unique case (op)
      OP_TICK: begin
        if (lead_seen_r) begin
          high_seen_nxt = 1'b0;
          if (tick_count_r == 4'd0) begin
            key_ready_nxt = 1'b1;
          end
          if (tick_count_r < release_ticks) begin
            tick_count_nxt = tick_count_r + 4'd1;
          end else begin
            lead_seen_nxt  = 1'b0;
            tick_count_nxt = 4'd0;
          end
        end
      end
      OP_RISE: begin
        high_seen_nxt = 1'b1;
      end
      OP_FALL: begin
        high_seen_nxt = 1'b0;
        if (high_seen_r) begin
          if (lead_seen_r) begin
            if (win.bit0) begin
              code_shift_nxt = {code_shift_r[30:0], 1'b0};
            end else if (win.bit1) begin
              code_shift_nxt = {code_shift_r[30:0], 1'b1};
            end else if (win.rpt) begin
              repeats_nxt    = repeats_r + 8'd1;
              tick_count_nxt = 4'd0;
            end
          end else if (win.lead) begin
            lead_seen_nxt = 1'b1;
            repeats_nxt   = 8'd0;
          end
        end
      end
      OP_SCAN: begin
        // Drop the ready key and clear repeats on a failed check or after release
        if (key_ready_r && ((key == 8'd0) || !lead_seen_r)) begin
          key_ready_nxt = 1'b0;
          repeats_nxt   = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control flags and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_seen_r  <= 1'b0;
      key_ready_r  <= 1'b0;
      high_seen_r  <= 1'b0;
      tick_count_r <= 4'd0;
      code_shift_r <= 32'd0;
      repeats_r    <= 8'd0;
    end else if (en) begin
      lead_seen_r  <= lead_seen_nxt;
      key_ready_r  <= key_ready_nxt;
      high_seen_r  <= high_seen_nxt;
      tick_count_r <= tick_count_nxt;
      code_shift_r <= code_shift_nxt;
      repeats_r    <= repeats_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: verif/nec_ir_pulse_width_decoder_tb.sv
// Self-checking testbench for nec_ir_pulse_width_decoder: a directed table of
// events, then random NEC frames, repeats, ticks and noise under several settings.
// Depends on nec_ir_pkg and the RTL of the decoder only.
`timescale 1ns / 100ps

module nec_ir_pulse_width_decoder_tb;
  import nec_ir_pkg::*;

  localparam int PHASES         = 6;
  localparam int PHASE_WORDS    = 220;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIR_ROWS       = 24;
  localparam int MAX_PRINTED    = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // Typed expectation that travels with the word being offered
  bit          in_typed = 1'b0;
  res_t        in_typed_res = '0;

  nec_ir_pulse_width_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder state as the testbench sees it
  logic        dec_lead = 1'b0;
  logic        dec_ready = 1'b0;
  logic        dec_high = 1'b0;
  logic [3:0]  dec_ticks = '0;
  logic [31:0] dec_code = '0;
  logic [7:0]  dec_repeats = '0;
  logic [7:0]  dec_dev_addr = DEV_ADDR_RST;
  logic [3:0]  dec_release = RELEASE_TICKS_RST;

  res_t scan_results[$];

  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_keys = 0;
  int n_cfg = 0;
  int phase_words = 0;
  int burst_left = 1;
  int quiet_cycles = 0;
  int stall_left = 0;
  int cyc = 0;
  logic [7:0] phase_id = DEV_ADDR_RST;

  // Widths on and next to every window limit
  logic [15:0] window_limits [18] = '{
    16'd0, BIT0_LO, BIT0_LO + 16'd1, BIT0_HI - 16'd1, BIT0_HI,
    BIT1_LO, BIT1_LO + 16'd1, BIT1_HI - 16'd1, BIT1_HI,
    REP_LO, REP_LO + 16'd1, REP_HI - 16'd1, REP_HI,
    LEAD_LO, LEAD_LO + 16'd1, LEAD_HI - 16'd1, LEAD_HI, 16'hFFFF
  };

  typedef struct {
    op_t         op;
    logic [15:0] width;
    bit          typed;
    res_t        res;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS];

  function automatic res_t scan_word(bit active, logic [7:0] rep, bit valid, logic [7:0] key);
    res_t r;
    r.frame_active = active;
    r.repeat_count = rep;
    r.key_valid    = valid;
    r.key_code     = key;
    return r;
  endfunction

  function automatic bit in_win(logic [15:0] w, logic [15:0] lo, logic [15:0] hi);
    return w > lo && w < hi;
  endfunction

  // Advance the decoder state by one event; return 1 with the scan result on a scan
  function automatic bit decode_event(input op_t op, input logic [15:0] w, output res_t res);
    logic [7:0] addr;
    logic [7:0] key;
    res = '0;
    key = '0;
    case (op)
      OP_TICK: begin
        if (dec_lead) begin
          dec_high = 1'b0;
          if (dec_ticks == 4'd0) dec_ready = 1'b1;
          if (dec_ticks < dec_release) begin
            dec_ticks = dec_ticks + 4'd1;
          end else begin
            dec_lead  = 1'b0;
            dec_ticks = '0;
          end
        end
        return 1'b0;
      end
      OP_RISE: begin
        dec_high = 1'b1;
        return 1'b0;
      end
      OP_FALL: begin
        if (dec_high) begin
          if (dec_lead) begin
            if (in_win(w, BIT0_LO, BIT0_HI)) begin
              dec_code = {dec_code[30:0], 1'b0};
            end else if (in_win(w, BIT1_LO, BIT1_HI)) begin
              dec_code = {dec_code[30:0], 1'b1};
            end else if (in_win(w, REP_LO, REP_HI)) begin
              dec_repeats = dec_repeats + 8'd1;
              dec_ticks   = '0;
            end
          end else if (in_win(w, LEAD_LO, LEAD_HI)) begin
            dec_lead    = 1'b1;
            dec_repeats = '0;
          end
        end
        dec_high = 1'b0;
        return 1'b0;
      end
      default: begin
        res.repeat_count = dec_repeats;
        res.frame_active = dec_lead;
        if (dec_ready) begin
          addr = dec_code[31:24];
          if (addr == ~dec_code[23:16] && addr == dec_dev_addr &&
              dec_code[15:8] == ~dec_code[7:0])
            key = dec_code[15:8];
          // failed scan or released frame drops the key
          if (key == 8'd0 || !dec_lead) begin
            dec_ready   = 1'b0;
            dec_repeats = '0;
          end
        end
        res.key_code  = key;
        res.key_valid = key != 8'd0;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("scan result %0d: %s got 0x%0h want 0x%0h", n_checked, what, got, want);
  endtask

  // Monitor: check results, predict accepted words, track register writes
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    res_t pred;
    bit   is_scan;
    if (!rst_n) begin
      dec_lead = 1'b0; dec_ready = 1'b0; dec_high = 1'b0;
      dec_ticks = '0; dec_code = '0; dec_repeats = '0;
      dec_dev_addr = DEV_ADDR_RST;
      dec_release = RELEASE_TICKS_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[17:0]);
        if (scan_results.size() == 0) begin
          report_mismatch("result word with no scan pending, tdata", out_tdata, 0);
        end else begin
          want = scan_results.pop_front();
          if (got.key_code != want.key_code)
            report_mismatch("key_code", got.key_code, want.key_code);
          if (got.key_valid != want.key_valid)
            report_mismatch("key_valid", got.key_valid, want.key_valid);
          if (got.repeat_count != want.repeat_count)
            report_mismatch("repeat_count", got.repeat_count, want.repeat_count);
          if (got.frame_active != want.frame_active)
            report_mismatch("frame_active", got.frame_active, want.frame_active);
          if (out_tdata[23:18] != '0)
            report_mismatch("padding bits", out_tdata[23:18], 0);
          if (got.key_valid) n_keys++;
          n_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        is_scan = decode_event(op_t'(in_tuser), in_tdata, pred);
        if (is_scan) scan_results.push_back(in_typed ? in_typed_res : pred);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DEV_ADDR) dec_dev_addr = cfg_data;
        else if (cfg_index == REG_RELEASE_TICKS) dec_release = cfg_data[3:0];
      end
    end
  end

  // Watchdog: end the run when no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, scan_results.size());
      $display("nec_ir_pulse_width_decoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: free-running stretches, then random stalls of growing density
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (cyc[9:8] == 2'd0) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 7) < cyc[9:8]) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one word and hold it until accepted; often idle between bursts
  task automatic send_word(op_t op, logic [15:0] w, bit typed, res_t res);
    in_tvalid    <= 1'b1;
    in_tuser     <= op;
    in_tdata     <= w;
    in_typed     <= typed;
    in_typed_res <= res;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    phase_words++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic send_event(op_t op, logic [15:0] w);
    send_word(op, w, 1'b0, '0);
  endtask

  task automatic send_pulse(logic [15:0] w);
    send_event(OP_RISE, 16'($urandom));
    send_event(OP_FALL, w);
  endtask

  function automatic logic [15:0] bit_width(bit one);
    return one ? 16'($urandom_range(BIT1_LO + 1, BIT1_HI - 1))
               : 16'($urandom_range(BIT0_LO + 1, BIT0_HI - 1));
  endfunction

  function automatic logic [15:0] odd_width();
    case ($urandom_range(0, 2))
      0:       return window_limits[$urandom_range(0, 17)];
      1:       return 16'($urandom_range(0, 5000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Lead code followed by the top n_bits of code, MSB first; bad_bit gets a stray width
  task automatic send_frame(logic [31:0] code, int n_bits, int bad_bit);
    send_pulse(16'($urandom_range(LEAD_LO + 1, LEAD_HI - 1)));
    for (int i = 31; i > 31 - n_bits; i--)
      send_pulse(i == bad_bit ? odd_width() : bit_width(code[i]));
  endtask

  // Age, scan, repeat and disturb a frame, sometimes until it is released
  task automatic frame_tail();
    if ($urandom_range(0, 9) < 7) begin
      send_event(OP_TICK, 16'($urandom));
      send_event(OP_SCAN, 16'($urandom));
    end
    repeat ($urandom_range(2, 20)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_event(OP_TICK, 16'($urandom));
        4, 5, 6:    send_event(OP_SCAN, 16'($urandom));
        7:          send_pulse(16'($urandom_range(REP_LO + 1, REP_HI - 1)));
        8:          send_pulse(odd_width());
        default:    send_event(op_t'($urandom_range(0, 3)), odd_width());
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      repeat (17) send_event(OP_TICK, 16'($urandom));
      send_event(OP_SCAN, 16'($urandom));
    end
  endtask

  // Drop valid, wait for every pending result, then let the pipeline empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scan_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    n_cfg++;
  endtask

  initial begin : stimulus
    logic [7:0]  rel_data;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [31:0] code;
    int          n_bits;
    int          bad_bit;

    dir_rows = '{
      '{OP_SCAN, 16'd0,      1'b1, scan_word(0, 8'd0, 0, 8'd0)},  // scan after reset
      '{OP_FALL, 16'hFFFF,   1'b0, '0},  // falling edge without rising edge
      '{OP_TICK, 16'hFFFF,   1'b0, '0},  // tick with no frame
      '{OP_RISE, 16'hFFFF,   1'b0, '0},
      '{OP_FALL, LEAD_LO,    1'b0, '0},  // just below lead window
      '{OP_RISE, 16'h0000,   1'b0, '0},
      '{OP_FALL, LEAD_LO + 16'd1, 1'b0, '0},  // lead code
      '{OP_RISE, 16'h5555,   1'b0, '0},
      '{OP_FALL, REP_HI - 16'd1,  1'b0, '0},  // repeat code
      '{OP_RISE, 16'hAAAA,   1'b0, '0},
      '{OP_FALL, 16'd0,      1'b0, '0},  // unclassified width
      '{OP_SCAN, 16'hFFFF,   1'b1, scan_word(1, 8'd1, 0, 8'd0)},  // no key ready
      '{OP_TICK, 16'd0,      1'b0, '0},  // first tick marks key ready
      '{OP_SCAN, 16'd0,      1'b1, scan_word(1, 8'd1, 0, 8'd0)},  // bad address, fails
      '{OP_SCAN, 16'd0,      1'b1, scan_word(1, 8'd0, 0, 8'd0)},  // ready and repeats cleared
      '{OP_RISE, 16'd0,      1'b0, '0},
      '{OP_FALL, BIT0_LO + 16'd1, 1'b0, '0},
      '{OP_RISE, 16'd0,      1'b0, '0},
      '{OP_FALL, BIT1_HI - 16'd1, 1'b0, '0},
      '{OP_RISE, 16'd0,      1'b0, '0},
      '{OP_FALL, LEAD_HI - 16'd1, 1'b0, '0},  // lead width while a frame is open
      '{OP_SCAN, 16'd0,      1'b0, '0},
      '{OP_TICK, 16'd0,      1'b0, '0},
      '{OP_SCAN, 16'd0,      1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].width, dir_rows[i].typed, dir_rows[i].res);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0:       begin phase_id = 8'h00; rel_data = 8'd1;  end
        1:       begin phase_id = 8'hFF; rel_data = 8'd15; end
        2:       begin phase_id = 8'($urandom); rel_data = 8'd0; end
        3:       begin phase_id = 8'($urandom); rel_data = 8'hA3; end  // upper nibble ignored
        4:       begin phase_id = 8'($urandom); rel_data = 8'($urandom_range(0, 15)); end
        default: begin phase_id = 8'($urandom); rel_data = 8'd14; end
      endcase
      if (ph[0]) begin
        write_reg(REG_RELEASE_TICKS, rel_data);
        write_reg(REG_DEV_ADDR, phase_id);
      end else begin
        write_reg(REG_DEV_ADDR, phase_id);
        write_reg(REG_RELEASE_TICKS, rel_data);
      end
      cfg_valid <= 1'b0;

      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        addr = ($urandom_range(0, 3) != 0) ? phase_id : 8'($urandom);
        cmd  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
        code = {addr, ~addr, cmd, ~cmd};
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            send_frame(code, 32, -1);
            frame_tail();
          end
          6, 7: begin
            // broken frame: truncated, stray width or flipped bit
            n_bits  = 32;
            bad_bit = -1;
            case ($urandom_range(0, 2))
              0:       n_bits = $urandom_range(0, 31);
              1:       bad_bit = $urandom_range(0, 31);
              default: code[$urandom_range(0, 31)] ^= 1'b1;
            endcase
            send_frame(code, n_bits, bad_bit);
            frame_tail();
          end
          default: begin
            repeat ($urandom_range(4, 16))
              send_event(op_t'($urandom_range(0, 3)), odd_width());
          end
        endcase
      end
    end

    wait_idle();
    $display("covered %0d input words over %0d register settings (%0d register writes)",
             n_sent, PHASES + 1, n_cfg);
    $display("checked %0d scan results, %0d of them with a validated key", n_checked, n_keys);
    if (n_errors == 0) begin
      $display("nec_ir_pulse_width_decoder regression: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("nec_ir_pulse_width_decoder regression: fail");
    end
    $finish;
  end

endmodule
